// File: design/xnb_pkg.sv
`timescale 1ns / 1ps
package xnb_pkg;

  localparam int BYTE_COUNT_BITS_DEF = 32;
  localparam int NODE_COUNT_BITS_DEF = 18;

  localparam int DEPTH_W     = 7;
  localparam int NODES_W     = 18;
  localparam int MAX_BYTES_W = 32;
  localparam int FAIL_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DEPTH_W-1:0]     MAX_DEPTH_RST = 7'd96;
  localparam logic [NODES_W-1:0]     MAX_NODES_RST = 18'd200000;
  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RST = 32'd16777216;

  localparam logic [FAIL_W-1:0] FAIL_OK         = 4'd0;
  localparam logic [FAIL_W-1:0] FAIL_OVERSIZE   = 4'd1;
  localparam logic [FAIL_W-1:0] FAIL_NUL        = 4'd2;
  localparam logic [FAIL_W-1:0] FAIL_BAD_MARKUP = 4'd3;
  localparam logic [FAIL_W-1:0] FAIL_NO_OPEN    = 4'd4;
  localparam logic [FAIL_W-1:0] FAIL_NODES      = 4'd5;
  localparam logic [FAIL_W-1:0] FAIL_DEEP       = 4'd6;
  localparam logic [FAIL_W-1:0] FAIL_UNTERM     = 4'd7;
  localparam logic [FAIL_W-1:0] FAIL_EMPTY      = 4'd8;
  localparam logic [FAIL_W-1:0] FAIL_UNCLOSED   = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NODES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd2;

  // Expected character at each position of the "[CDATA[" opener.
  function automatic logic [7:0] cdata_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h54;
      3'd5:    c = 8'h41;
      3'd6:    c = 8'h5B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: design/xnb_ifs.sv
`timescale 1ns / 1ps
interface xnb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface xnb_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  fail_code;
  logic [17:0] node_total;

  modport source (output valid, output accepted, output fail_code, output node_total,
                  input ready);
  modport sink   (input valid, input accepted, input fail_code, input node_total,
                  output ready);
endinterface

interface xnb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/xml_nesting_budget_checker_unit.sv
`timescale 1ns / 1ps
// XML nesting budget checker.
// in_ch carries one document byte per item with last_byte marking the end of
// the document. out_ch carries one verdict item (accepted, fail_code,
// node_total) for each document, produced by the byte marked last; other
// bytes produce no item. cfg_ch writes max_depth (index 0), max_nodes (1)
// and max_bytes (2); it is always ready and must only be used while idle.
// Each byte updates the scan state in the cycle it is accepted, so one byte
// per cycle is sustained while no verdict is stalled on out_ch; the limit is
// the single state update path from the accepted byte to the scan registers.
// A verdict appears on out_ch in the cycle after its last byte is accepted.
// The verdict sits in an output register. When the receiver stalls it holds
// there and in_ch.ready stays low, so no byte is taken until the held verdict
// is taken; a verdict taken in the same cycle frees the input at once.
// Reset (rst_n low, synchronous) clears the scan state and the output valid
// and loads the limits with 96, 200000 and 16777216. After each verdict the
// scan state clears and the limits keep their values.
module xml_nesting_budget_checker_unit
  import xnb_pkg::*;
#(
  parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF,
  parameter int NODE_COUNT_BITS = NODE_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  xnb_in_if.sink     in_ch,
  xnb_out_if.source  out_ch,
  xnb_cfg_if.sink    cfg_ch
);

  localparam int BW = BYTE_COUNT_BITS;
  localparam int NW = NODE_COUNT_BITS;
  localparam int BCMP_W = (BW > MAX_BYTES_W) ? BW : MAX_BYTES_W;
  localparam int NCMP_W = (NW > NODES_W) ? NW : NODES_W;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  typedef enum logic [3:0] {
    M_TEXT, M_LT, M_BANG, M_BANG_DASH, M_CDATA_PFX,
    M_COMMENT, M_CDATA, M_PI, M_TAG
  } mode_t;

  // limits
  logic [DEPTH_W-1:0]     max_depth_r;
  logic [NODES_W-1:0]     max_nodes_r;
  logic [MAX_BYTES_W-1:0] max_bytes_r;

  // scan state
  mode_t              mode_r,    mode_nxt;
  logic [2:0]         pos_r,     pos_nxt;
  logic [1:0]         tail_r,    tail_nxt;
  logic [1:0]         quote_r,   quote_nxt;
  logic               closing_r, closing_nxt;
  logic               slash_r,   slash_nxt;
  logic [DEPTH_W-1:0] depth_r,   depth_nxt;
  logic [NW-1:0]      nodes_r,   nodes_nxt;
  logic [BW-1:0]      bytes_r,   bytes_nxt;
  logic [1:0]         flags_r,   flags_nxt;
  logic [FAIL_W-1:0]  err_r,     err_nxt;

  // verdict register
  logic               out_valid_r;
  logic               accepted_r,  accepted_nxt;
  logic [FAIL_W-1:0]  fail_r,      fail_nxt;
  logic [NODES_W-1:0] total_r,     total_nxt;

  logic               in_fire;
  logic [7:0]         b;
  logic               do_tag;
  logic [NCMP_W-1:0]  nodes_ext;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign b            = in_ch.data_byte;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = accepted_r;
  assign out_ch.fail_code  = fail_r;
  assign out_ch.node_total = total_r;

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    tail_nxt    = tail_r;
    quote_nxt   = quote_r;
    closing_nxt = closing_r;
    slash_nxt   = slash_r;
    depth_nxt   = depth_r;
    nodes_nxt   = nodes_r;
    bytes_nxt   = bytes_r;
    flags_nxt   = flags_r;
    err_nxt     = err_r;
    do_tag      = 1'b0;

    // size and nul checks run on every byte
    if (bytes_r == {BW{1'b1}}) begin
      flags_nxt[0] = 1'b1;
    end else begin
      bytes_nxt = bytes_r + BW'(1);
      if (BCMP_W'(bytes_nxt) > BCMP_W'(max_bytes_r)) flags_nxt[0] = 1'b1;
    end
    if (b == CH_NUL) flags_nxt[1] = 1'b1;

    if (err_r == FAIL_OK) begin
      unique case (mode_r)
        M_TEXT: begin
          if (b == CH_LT) mode_nxt = M_LT;
        end
        M_LT: begin
          if (b == CH_QMARK) begin
            mode_nxt = M_PI;
            tail_nxt = 2'd0;
          end else if (b == CH_BANG) begin
            mode_nxt = M_BANG;
          end else begin
            closing_nxt = (b == CH_SLASH);
            slash_nxt   = 1'b0;
            quote_nxt   = Q_NONE;
            mode_nxt    = M_TAG;
            do_tag      = 1'b1;
          end
        end
        M_BANG: begin
          if (b == CH_DASH) begin
            mode_nxt = M_BANG_DASH;
          end else if (b == CH_LBRACK) begin
            mode_nxt = M_CDATA_PFX;
            pos_nxt  = 3'd1;
          end else begin
            err_nxt = FAIL_BAD_MARKUP;
          end
        end
        M_BANG_DASH: begin
          if (b == CH_DASH) begin
            mode_nxt = M_COMMENT;
            tail_nxt = 2'd0;
          end else begin
            err_nxt = FAIL_BAD_MARKUP;
          end
        end
        M_CDATA_PFX: begin
          if (pos_r != 3'd7 && b == cdata_char(pos_r)) begin
            pos_nxt = pos_r + 3'd1;
            if (pos_r == 3'd6) begin
              mode_nxt = M_CDATA;
              tail_nxt = 2'd0;
              pos_nxt  = 3'd0;
            end
          end else begin
            err_nxt = FAIL_BAD_MARKUP;
          end
        end
        M_COMMENT, M_CDATA: begin
          if (b == ((mode_r == M_COMMENT) ? CH_DASH : CH_RBRACK)) begin
            if (tail_r != 2'd2) tail_nxt = tail_r + 2'd1;
          end else if (b == CH_GT && tail_r == 2'd2) begin
            mode_nxt = M_TEXT;
            tail_nxt = 2'd0;
          end else begin
            tail_nxt = 2'd0;
          end
        end
        M_PI: begin
          if (b == CH_GT && tail_r == 2'd1) begin
            mode_nxt = M_TEXT;
            tail_nxt = 2'd0;
          end else begin
            tail_nxt = (b == CH_QMARK) ? 2'd1 : 2'd0;
          end
        end
        M_TAG: begin
          do_tag = 1'b1;
        end
        default: begin
          mode_nxt = M_TEXT;
        end
      endcase

      if (do_tag) begin
        if (quote_nxt != Q_NONE) begin
          if ((quote_nxt == Q_SINGLE && b == CH_APOS) ||
              (quote_nxt == Q_DOUBLE && b == CH_QUOTE))
            quote_nxt = Q_NONE;
          slash_nxt = (b == CH_SLASH);
        end else if (b == CH_APOS) begin
          quote_nxt = Q_SINGLE;
          slash_nxt = 1'b0;
        end else if (b == CH_QUOTE) begin
          quote_nxt = Q_DOUBLE;
          slash_nxt = 1'b0;
        end else if (b == CH_LT) begin
          err_nxt = FAIL_BAD_MARKUP;
        end else if (b == CH_GT) begin
          mode_nxt = M_TEXT;
          // finish the tag: close, or count an opening tag
          if (closing_nxt) begin
            if (depth_r == '0) err_nxt = FAIL_NO_OPEN;
            else depth_nxt = depth_r - DEPTH_W'(1);
          end else if (NCMP_W'(nodes_r) >= NCMP_W'(max_nodes_r) ||
                       nodes_r == {NW{1'b1}}) begin
            err_nxt = FAIL_NODES;
          end else begin
            nodes_nxt = nodes_r + NW'(1);
            if (!slash_nxt) begin
              if (depth_r >= max_depth_r) err_nxt = FAIL_DEEP;
              else depth_nxt = depth_r + DEPTH_W'(1);
            end
          end
        end else begin
          slash_nxt = (b == CH_SLASH);
        end
      end
    end

    // verdict on the state after this byte
    nodes_ext = NCMP_W'(nodes_nxt);
    total_nxt = nodes_ext[NODES_W-1:0];
    if (flags_nxt[0])                 fail_nxt = FAIL_OVERSIZE;
    else if (flags_nxt[1])            fail_nxt = FAIL_NUL;
    else if (err_nxt != FAIL_OK)      fail_nxt = err_nxt;
    else if (mode_nxt == M_BANG || mode_nxt == M_BANG_DASH ||
             mode_nxt == M_CDATA_PFX) fail_nxt = FAIL_BAD_MARKUP;
    else if (mode_nxt != M_TEXT)      fail_nxt = FAIL_UNTERM;
    else if (nodes_nxt == '0)         fail_nxt = FAIL_EMPTY;
    else if (depth_nxt != '0)         fail_nxt = FAIL_UNCLOSED;
    else                              fail_nxt = FAIL_OK;
    accepted_nxt = (fail_nxt == FAIL_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r <= MAX_DEPTH_RST;
      max_nodes_r <= MAX_NODES_RST;
      max_bytes_r <= MAX_BYTES_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MAX_DEPTH: max_depth_r <= cfg_ch.data[DEPTH_W-1:0];
        CFG_MAX_NODES: max_nodes_r <= cfg_ch.data[NODES_W-1:0];
        CFG_MAX_BYTES: max_bytes_r <= cfg_ch.data[MAX_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_ch.last_byte)) begin
      // clear the scan state at reset and after every verdict
      mode_r    <= M_TEXT;
      pos_r     <= '0;
      tail_r    <= '0;
      quote_r   <= Q_NONE;
      closing_r <= 1'b0;
      slash_r   <= 1'b0;
      depth_r   <= '0;
      nodes_r   <= '0;
      bytes_r   <= '0;
      flags_r   <= '0;
      err_r     <= FAIL_OK;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      tail_r    <= tail_nxt;
      quote_r   <= quote_nxt;
      closing_r <= closing_nxt;
      slash_r   <= slash_nxt;
      depth_r   <= depth_nxt;
      nodes_r   <= nodes_nxt;
      bytes_r   <= bytes_nxt;
      flags_r   <= flags_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.last_byte) begin
      accepted_r <= accepted_nxt;
      fail_r     <= fail_nxt;
      total_r    <= total_nxt;
    end
  end

endmodule

// File: design/xnb_checker.sv
`timescale 1ns / 1ps
module xnb_checker
  import xnb_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         in_last,
  input logic         out_valid,
  input logic         out_ready,
  input logic         out_accepted,
  input logic [3:0]   out_fail_code,
  input logic [17:0]  out_node_total
);

  // a stalled verdict stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_accepted) && $stable(out_fail_code) && $stable(out_node_total))
    else $error("verdict changed while stalled");

  a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_fail_code == FAIL_OK)))
    else $error("accepted flag disagrees with fail code");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fail_code <= FAIL_UNCLOSED))
    else $error("fail code out of range");

  // only a last byte produces a verdict
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready && in_last)) && (!out_valid || out_ready) |=> !out_valid)
    else $error("verdict without a last byte");

endmodule

bind xml_nesting_budget_checker_unit xnb_checker u_xnb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last        (in_ch.last_byte),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_accepted   (out_ch.accepted),
  .out_fail_code  (out_ch.fail_code),
  .out_node_total (out_ch.node_total)
);
